>>> design/wwcm_pkg.sv
// wwcm_pkg: shared widths, register indexes and byte helpers for the
// whole-word caseless matcher. No dependencies.
package wwcm_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_LANES = CFG_W / BYTE_W;

    localparam logic [LEN_W-1:0] SEEN_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LO  = 2'd0,
        CFG_NEEDLE_HI  = 2'd1,
        CFG_NEEDLE_LEN = 2'd2
    } t_cfg_idx;

    function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage

>>> design/wwcm_in_if.sv
// wwcm_in_if: valid/ready channel for haystack bytes.
// Depends on wwcm_pkg for widths.
interface wwcm_in_if;
    logic                          valid;
    logic                          ready;
    logic [wwcm_pkg::BYTE_W-1:0]   hay_byte;
    logic                          last_byte;

    modport source (output valid, output hay_byte, output last_byte, input ready);
    modport sink   (input valid, input hay_byte, input last_byte, output ready);
endinterface

>>> design/wwcm_out_if.sv
// wwcm_out_if: valid/ready channel for the per-haystack found result.
// No dependencies.
interface wwcm_out_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

>>> design/whole_word_caseless_matcher_core.sv
// whole_word_caseless_matcher_core: top level; input register, scan state,
// result register. Depends on wwcm_pkg, wwcm_in_if, wwcm_out_if, wwcm_cfg, wwcm_window.
//
//   port      dir   handshake     payload
//   i_hay     in    valid/ready   hay_byte[7:0], last_byte
//   o_res     out   valid/ready   found
//   i_cfg_*   in    write enable  i_cfg_idx[1:0], i_cfg_data[63:0]
//
// one item per cycle sustained unless a last byte waits on a stalled result; a
// result goes valid via the input register, then compare into the result register.
// reset clears scan state, needle registers and both valid flags.
// a stalled result only holds back a following last byte: it waits in the
// input register and ready drops until the result is taken.
module whole_word_caseless_matcher_core #(
    parameter int unsigned MAX_NEEDLE = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wwcm_in_if.sink                            i_hay,
    wwcm_out_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [wwcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wwcm_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [MAX_NEEDLE-1:0][wwcm_pkg::BYTE_W-1:0] needle;
    logic [wwcm_pkg::LEN_W-1:0]                  len;

    logic                          r_in_valid;
    logic [wwcm_pkg::BYTE_W-1:0]   r_in_byte;
    logic                          r_in_last;
    logic [wwcm_pkg::LEN_W-1:0]    r_seen;
    logic [wwcm_pkg::LEN_W-1:0]    n_seen;
    logic                          r_pending;
    logic                          r_found;
    logic                          r_out_valid;
    logic                          r_out_found;

    logic                          go;
    logic                          hit;
    logic                          found_mid;

    wwcm_cfg #(.MAX_NEEDLE(MAX_NEEDLE)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_needle   (needle),
        .o_len      (len)
    );

    // a last byte needs a free result slot, other bytes never wait
    assign go          = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_hay.ready = !r_in_valid || go;

    assign n_seen    = (r_seen == wwcm_pkg::SEEN_MAX) ? r_seen
                                                     : r_seen + wwcm_pkg::LEN_W'(1);
    assign found_mid = r_found || (r_pending && !wwcm_pkg::is_word_char(r_in_byte));

    wwcm_window #(.MAX_NEEDLE(MAX_NEEDLE)) u_window (
        .i_clk    (i_clk),
        .i_shift  (go),
        .i_byte   (wwcm_pkg::fold_lower(r_in_byte)),
        .i_needle (needle),
        .i_len    (len),
        .i_seen   (n_seen),
        .o_hit    (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_hay.valid && i_hay.ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hay.valid && i_hay.ready) begin
            r_in_byte <= i_hay.hay_byte;
            r_in_last <= i_hay.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_pending <= 1'b0;
            r_found   <= 1'b0;
        end else if (go) begin
            if (r_in_last) begin
                r_seen    <= '0;
                r_pending <= 1'b0;
                r_found   <= 1'b0;
            end else begin
                r_seen    <= n_seen;
                r_pending <= hit;
                r_found   <= found_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && r_in_last) begin
            r_out_found <= found_mid || hit;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.found = r_out_found;

endmodule

>>> design/wwcm_cfg.sv
// wwcm_cfg: needle registers, stored already lowercased, plus needle length.
// Depends on wwcm_pkg.
module wwcm_cfg #(
    parameter int unsigned MAX_NEEDLE = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [wwcm_pkg::CFG_IDX_W-1:0]                i_cfg_idx,
    input  logic [wwcm_pkg::CFG_W-1:0]                    i_cfg_data,
    output logic [MAX_NEEDLE-1:0][wwcm_pkg::BYTE_W-1:0]   o_needle,
    output logic [wwcm_pkg::LEN_W-1:0]                    o_len
);

    logic [MAX_NEEDLE-1:0][wwcm_pkg::BYTE_W-1:0] r_needle;
    logic [wwcm_pkg::LEN_W-1:0]                  r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle <= '0;
            r_len    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wwcm_pkg::CFG_NEEDLE_LO: begin
                    for (int j = 0; j < MAX_NEEDLE; j++) begin
                        if (j < wwcm_pkg::CFG_LANES) begin
                            r_needle[j] <= wwcm_pkg::fold_lower(
                                i_cfg_data[(j % wwcm_pkg::CFG_LANES) * wwcm_pkg::BYTE_W
                                           +: wwcm_pkg::BYTE_W]);
                        end
                    end
                end
                wwcm_pkg::CFG_NEEDLE_HI: begin
                    for (int j = 0; j < MAX_NEEDLE; j++) begin
                        if (j >= wwcm_pkg::CFG_LANES) begin
                            r_needle[j] <= wwcm_pkg::fold_lower(
                                i_cfg_data[(j % wwcm_pkg::CFG_LANES) * wwcm_pkg::BYTE_W
                                           +: wwcm_pkg::BYTE_W]);
                        end
                    end
                end
                wwcm_pkg::CFG_NEEDLE_LEN: begin
                    r_len <= i_cfg_data[wwcm_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_needle = r_needle;
    assign o_len    = r_len;

endmodule

>>> design/wwcm_window.sv
// wwcm_window: shift window of recent lowercased bytes and the parallel
// needle compare with left-edge test. Depends on wwcm_pkg.
module wwcm_window #(
    parameter int unsigned MAX_NEEDLE = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_shift,
    input  logic [wwcm_pkg::BYTE_W-1:0]                   i_byte,
    input  logic [MAX_NEEDLE-1:0][wwcm_pkg::BYTE_W-1:0]   i_needle,
    input  logic [wwcm_pkg::LEN_W-1:0]                    i_len,
    input  logic [wwcm_pkg::LEN_W-1:0]                    i_seen,
    output logic                                          o_hit
);

    localparam int unsigned DEPTH = MAX_NEEDLE + 1;
    localparam int unsigned IW    = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int unsigned WW    = $clog2(DEPTH);

    logic [wwcm_pkg::BYTE_W-1:0] r_win [DEPTH];
    logic [wwcm_pkg::BYTE_W-1:0] n_win [DEPTH];
    logic                        eq;
    logic                        len_ok;
    logic                        left_ok;

    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < DEPTH; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // window content is only read where the byte count says it was written
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= n_win;
        end
    end

    // newest byte lines up with the last needle byte
    always_comb begin
        logic [wwcm_pkg::LEN_W-1:0] idx;
        eq  = 1'b1;
        idx = '0;
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            if (wwcm_pkg::LEN_W'(k) < i_len) begin
                idx = i_len - wwcm_pkg::LEN_W'(k + 1);
                if (n_win[k] != i_needle[idx[IW-1:0]]) begin
                    eq = 1'b0;
                end
            end
        end
    end

    assign len_ok  = (i_len != '0) && (i_len <= wwcm_pkg::LEN_W'(MAX_NEEDLE)) &&
                     (i_seen >= i_len);
    assign left_ok = (i_seen == i_len) || !wwcm_pkg::is_word_char(n_win[i_len[WW-1:0]]);
    assign o_hit   = len_ok && eq && left_ok;

endmodule
